/* hw/rtl/noekeon_block_cipher_defines.svh */
// Assertion macros used by the checker file.
`ifndef NOEKEON_BLOCK_CIPHER_DEFINES_SVH
`define NOEKEON_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define NBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("noekeon check failed");

// Next-cycle implication, masked while reset is active.
`define NBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("noekeon check failed");

// Next-cycle implication that also covers the reset cycles.
`define NBC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("noekeon check failed");

`endif

/* hw/rtl/nbc_pkg.sv */
package nbc_pkg;

  localparam int MAX_ROUNDS = 32;
  localparam logic [5:0] DEFAULT_ROUNDS = 6'd16;

  // Configuration register indexes
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t REG_KEY_HI = 2'd0;
  localparam cfg_addr_t REG_KEY_LO = 2'd1;
  localparam cfg_addr_t REG_ROUNDS = 2'd2;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_ENC,
    MODE_DEC,
    MODE_KEY
  } mode_t;

  typedef enum logic [2:0] {
    ST_LOAD_KEY,
    ST_DERIVE,
    ST_KEY_THETA,
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [31:0] word_t;
  typedef word_t [0:3] blk_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_blk;
    logic load_key;
    logic step;
    logic store_dkey;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
  } sts_t;

  function automatic logic [7:0] round_const(logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0: c = 8'h80;   6'd1: c = 8'h1B;   6'd2: c = 8'h36;   6'd3: c = 8'h6C;
      6'd4: c = 8'hD8;   6'd5: c = 8'hAB;   6'd6: c = 8'h4D;   6'd7: c = 8'h9A;
      6'd8: c = 8'h2F;   6'd9: c = 8'h5E;   6'd10: c = 8'hBC;  6'd11: c = 8'h63;
      6'd12: c = 8'hC6;  6'd13: c = 8'h97;  6'd14: c = 8'h35;  6'd15: c = 8'h6A;
      6'd16: c = 8'hD4;  6'd17: c = 8'hB3;  6'd18: c = 8'h7D;  6'd19: c = 8'hFA;
      6'd20: c = 8'hEF;  6'd21: c = 8'hC5;  6'd22: c = 8'h91;  6'd23: c = 8'h39;
      6'd24: c = 8'h72;  6'd25: c = 8'hE4;  6'd26: c = 8'hD3;  6'd27: c = 8'hBD;
      6'd28: c = 8'h61;  6'd29: c = 8'hC2;  6'd30: c = 8'h9F;  6'd31: c = 8'h25;
      6'd32: c = 8'h4A;  6'd33: c = 8'h94;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t spread(word_t t);
    return t ^ rotl(t, 8) ^ rotl(t, 24);
  endfunction

  // Linear mixing layer with key addition
  function automatic blk_t theta(blk_t x, blk_t k);
    blk_t  y;
    word_t t;
    y = x;
    t = spread(y[0] ^ y[2]);
    y[1] = y[1] ^ t;
    y[3] = y[3] ^ t;
    y = y ^ k;
    t = spread(y[1] ^ y[3]);
    y[0] = y[0] ^ t;
    y[2] = y[2] ^ t;
    return y;
  endfunction

  // pi1, gamma, pi2
  function automatic blk_t pi_gamma_pi(blk_t x);
    blk_t  y;
    word_t t;
    y = x;
    y[1] = rotl(y[1], 1);
    y[2] = rotl(y[2], 5);
    y[3] = rotl(y[3], 2);
    y[1] = y[1] ^ ~(y[3] | y[2]);
    y[0] = y[0] ^ (y[2] & y[1]);
    t = y[3];
    y[3] = y[0];
    y[0] = t;
    y[2] = y[2] ^ y[0] ^ y[1] ^ y[3];
    y[1] = y[1] ^ ~(y[3] | y[2]);
    y[0] = y[0] ^ (y[2] & y[1]);
    y[1] = rotl(y[1], 31);
    y[2] = rotl(y[2], 27);
    y[3] = rotl(y[3], 30);
    return y;
  endfunction

endpackage

/* hw/rtl/nbc_ctrl.sv */
module nbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cfg_we,
  input  nbc_pkg::cfg_addr_t cfg_addr,
  input  nbc_pkg::sts_t      sts,
  output nbc_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);

  nbc_pkg::state_t state, state_next;
  logic            done_next;
  logic            cfg_hit;

  assign cfg_hit = cfg_we && (cfg_addr == nbc_pkg::REG_KEY_HI ||
                              cfg_addr == nbc_pkg::REG_KEY_LO ||
                              cfg_addr == nbc_pkg::REG_ROUNDS);

  // State and strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nbc_pkg::ST_LOAD_KEY;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done_next  = 1'b0;
    unique case (state)
      nbc_pkg::ST_LOAD_KEY: begin
        cmd.load_key = 1'b1;
        state_next   = nbc_pkg::ST_DERIVE;
      end
      nbc_pkg::ST_DERIVE: begin
        cmd.step = 1'b1;
        if (sts.last) state_next = nbc_pkg::ST_KEY_THETA;
      end
      nbc_pkg::ST_KEY_THETA: begin
        cmd.store_dkey = 1'b1;
        state_next     = nbc_pkg::ST_IDLE;
      end
      nbc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_blk = 1'b1;
          state_next   = nbc_pkg::ST_RUN;
        end
      end
      nbc_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        // final step: free the core for the next word
        if (sts.last) begin
          done_next = 1'b1;
          busy      = 1'b0;
          if (start) cmd.load_blk = 1'b1;
          else state_next = nbc_pkg::ST_IDLE;
        end
      end
      default: state_next = nbc_pkg::ST_LOAD_KEY;
    endcase
    // A write to a known register restarts key derivation
    if (cfg_hit) state_next = nbc_pkg::ST_LOAD_KEY;
  end

endmodule

/* hw/rtl/nbc_datapath.sv */
module nbc_datapath #(
  parameter int MAX_ROUNDS = nbc_pkg::MAX_ROUNDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  nbc_pkg::cfg_addr_t cfg_addr,
  input  logic [63:0]        cfg_data,
  input  nbc_pkg::in_t       src,
  input  nbc_pkg::cmd_t      cmd,
  output nbc_pkg::sts_t      sts,
  output nbc_pkg::out_t      result
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  logic [63:0]        key_hi, key_lo;
  logic [5:0]         round_count;
  nbc_pkg::blk_t      working_key, decrypt_key;
  nbc_pkg::blk_t      x, x_next;
  nbc_pkg::blk_t      rkey, pre_rc, post_rc, rc_blk, th;
  nbc_pkg::mode_t     mode;
  logic [RW-1:0]      idx;
  logic [5:0]         rnd_sel, rnd_sat;
  logic [RW-1:0]      rounds;
  logic [7:0]         rc;
  logic               last;

  // Effective round count: zero means default, saturate at the maximum
  always_comb begin
    rnd_sel = (round_count == 6'd0) ? nbc_pkg::DEFAULT_ROUNDS : round_count;
    rnd_sat = (rnd_sel > 6'(MAX_ROUNDS)) ? 6'(MAX_ROUNDS) : rnd_sel;
  end
  assign rounds = rnd_sat[RW-1:0];

  assign last     = (mode == nbc_pkg::MODE_DEC) ? (idx == '0) : (idx == rounds);
  assign sts.last = last;

  // One round, or the final theta, per step
  always_comb begin
    rc        = nbc_pkg::round_const(6'(idx));
    rc_blk    = '0;
    rc_blk[0] = {24'd0, rc};
    case (mode)
      nbc_pkg::MODE_ENC: rkey = working_key;
      nbc_pkg::MODE_DEC: rkey = decrypt_key;
      default:           rkey = '0;
    endcase
    pre_rc  = (mode == nbc_pkg::MODE_DEC) ? '0 : rc_blk;
    post_rc = (mode == nbc_pkg::MODE_DEC) ? rc_blk : '0;
    th      = nbc_pkg::theta(x ^ pre_rc, rkey) ^ post_rc;
    x_next  = last ? th : nbc_pkg::pi_gamma_pi(th);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi      <= '0;
      key_lo      <= '0;
      round_count <= nbc_pkg::DEFAULT_ROUNDS;
    end else if (cfg_we) begin
      case (cfg_addr)
        nbc_pkg::REG_KEY_HI: key_hi      <= cfg_data;
        nbc_pkg::REG_KEY_LO: key_lo      <= cfg_data;
        nbc_pkg::REG_ROUNDS: round_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Round state, counter and mode; a load wins over a step
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= nbc_pkg::MODE_KEY;
      idx  <= '0;
    end else begin
      if (cmd.load_key) begin
        x    <= {key_hi, key_lo};
        idx  <= '0;
        mode <= nbc_pkg::MODE_KEY;
      end else if (cmd.load_blk) begin
        x <= {src.block_hi, src.block_lo};
        if (src.op == nbc_pkg::OP_DEC) begin
          mode <= nbc_pkg::MODE_DEC;
          idx  <= rounds;
        end else begin
          mode <= nbc_pkg::MODE_ENC;
          idx  <= '0;
        end
      end else if (cmd.step) begin
        x   <= x_next;
        idx <= (mode == nbc_pkg::MODE_DEC) ? idx - 1'b1 : idx + 1'b1;
      end
    end
  end

  // Capture derived keys and results
  always_ff @(posedge clk) begin
    if (cmd.step && last) begin
      if (mode == nbc_pkg::MODE_KEY) working_key <= th;
      else result <= th;
    end
    if (cmd.store_dkey) decrypt_key <= nbc_pkg::theta(working_key, '0);
  end

endmodule

/* hw/rtl/noekeon_block_cipher.sv */
// The result is captured at the final theta step, after all R rounds (R = effective rounds).
// A new word can be accepted during the final theta step of the previous one; one round of the
//   single round unit runs per cycle, then the final theta step.
// Reset and every write to a known register derive the keys again; busy stays high until derivation ends.
// Results are strobed for one cycle on done; the receiver cannot stall.
module noekeon_block_cipher #(
  parameter int MAX_ROUNDS = nbc_pkg::MAX_ROUNDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  nbc_pkg::in_t       src,
  output logic               done,
  output nbc_pkg::out_t      result,
  input  logic               cfg_we,
  input  nbc_pkg::cfg_addr_t cfg_addr,
  input  logic [63:0]        cfg_data
);

  nbc_pkg::cmd_t cmd;
  nbc_pkg::sts_t sts;

  nbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  nbc_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .src      (src),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

endmodule

/* hw/rtl/nbc_checker.sv */
`include "noekeon_block_cipher_defines.svh"

module nbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               cfg_we,
  input nbc_pkg::cfg_addr_t cfg_addr
);

  logic cfg_hit;

  // Write to one of the known registers
  assign cfg_hit = cfg_we && (cfg_addr == nbc_pkg::REG_KEY_HI ||
                              cfg_addr == nbc_pkg::REG_KEY_LO ||
                              cfg_addr == nbc_pkg::REG_ROUNDS);

  // Key derivation holds off input after reset
  `NBC_ASSERT_NEXT_ALWAYS(a_busy_after_rst, rst, busy)

  // A write to a known register starts derivation
  `NBC_ASSERT_NEXT(a_busy_after_cfg, cfg_hit, busy)

  // Results are never strobed twice in a row
  `NBC_ASSERT_NEXT(a_done_pulse, done, !done)

  // No result is strobed early after accepting a word
  `NBC_ASSERT_IMP(a_no_early_done, done, !$past(start && !busy, 2))

endmodule

bind noekeon_block_cipher nbc_checker u_nbc_checker (.*);
